### sv/bsr_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and coordinate helpers for the border-read matrix store
// no dependencies; imported by every module of the block

package bsr_pkg;

  localparam int MaxWidth   = 64;
  localparam int MaxHeight  = 64;
  localparam int WordBits   = 64;
  localparam int CoordBits  = 10;
  localparam int SizeBits   = 7;
  localparam int IdxBits    = $clog2(MaxWidth > MaxHeight ? MaxWidth : MaxHeight);
  localparam int StoreDepth = MaxWidth * MaxHeight;
  localparam int AddrBits   = $clog2(StoreDepth);
  localparam int ProdBits   = IdxBits + SizeBits;
  localparam int StepBits   = $clog2(CoordBits + 1);
  localparam int PaddrBits  = 4;
  localparam int PdataBits  = 32;

  localparam logic [SizeBits-1:0] WidthReset  = SizeBits'(MaxWidth);
  localparam logic [SizeBits-1:0] HeightReset = SizeBits'(MaxHeight);

  typedef enum logic [1:0] {
    BmReplicate = 2'd0,
    BmReflect   = 2'd1,
    BmWrap      = 2'd2,
    BmZero      = 2'd3
  } border_mode_e;

  typedef enum logic {
    ActRead  = 1'b0,
    ActWrite = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    RegWidth  = 2'd0,
    RegHeight = 2'd1,
    RegMode   = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StCheck,
    StMod,
    StAddr,
    StMem
  } state_e;

  typedef struct packed {
    logic                we;
    logic                re;
    logic [AddrBits-1:0] addr;
    logic [WordBits-1:0] wdata;
  } mem_req_t;

  // zero counts as one, anything above the maximum saturates
  function automatic logic [SizeBits-1:0] eff_size(input logic [SizeBits-1:0] raw,
                                                    input logic [SizeBits-1:0] maxv);
    logic [SizeBits-1:0] res;
    if (raw == '0) begin
      res = SizeBits'(1);
    end else if (raw > maxv) begin
      res = maxv;
    end else begin
      res = raw;
    end
    return res;
  endfunction

  function automatic logic coord_inside(input logic signed [CoordBits-1:0] c,
                                        input logic [SizeBits-1:0] n);
    return !c[CoordBits-1] && (c < $signed({{(CoordBits-SizeBits){1'b0}}, n}));
  endfunction

  // value whose remainder by n the border fold needs
  function automatic logic [CoordBits-1:0] fold_dividend(input logic signed [CoordBits-1:0] c,
                                                         input logic [SizeBits-1:0] n,
                                                         input border_mode_e mode);
    logic [CoordBits-1:0] res;
    if (c[CoordBits-1]) begin
      res = CoordBits'(-c);
    end else if (mode == BmReflect) begin
      res = CoordBits'(c) - CoordBits'(n);
    end else begin
      res = CoordBits'(c);
    end
    return res;
  endfunction

  function automatic logic [IdxBits-1:0] fold_coord(input logic signed [CoordBits-1:0] c,
                                                    input logic [SizeBits-1:0] n,
                                                    input border_mode_e mode,
                                                    input logic [IdxBits-1:0] rem,
                                                    input logic in_mat);
    logic [IdxBits-1:0] res;
    logic [IdxBits-1:0] last;
    last = IdxBits'(n - SizeBits'(1));
    res  = IdxBits'(c);
    if (!in_mat) begin
      unique case (mode)
        BmReplicate: res = c[CoordBits-1] ? '0 : last;
        BmReflect:   res = c[CoordBits-1] ? rem : IdxBits'(last - rem);
        BmWrap: begin
          if (!c[CoordBits-1]) begin
            res = rem;
          end else if (rem == '0) begin
            res = '0;
          end else begin
            res = IdxBits'(n - SizeBits'(rem));
          end
        end
        default:     res = '0;
      endcase
    end
    return res;
  endfunction

endpackage

### sv/matrix_store_border_read.sv
`timescale 1ns / 1ps
// top level of the border-read matrix store: config registers, sequencer, output register
// depends on bsr_pkg, bsr_mod_unit and bsr_store

// A row-major store of up to 64 by 64 words of 64 bits. A write beat stores write_value at
// (x_coord, y_coord) or, outside the configured matrix, stores nothing and returns range_error.
// A read beat folds signed coordinates back into the matrix by the border mode (replicate,
// reflect, wrap, zero outside) and returns the stored word. One item is in flight at a time:
// a new beat is taken only after the last one is done, and a reflect or wrap read outside
// the matrix takes longer, as the fold then runs a 10-step bit-serial remainder against the
// configured width and height before the single-port store is read. Results sit in an output
// register, so the next item is taken while a result waits. Reading a word never written
// since reset returns an undefined value. The store needs no clearing after reset.

module matrix_store_border_read (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // item channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 action_i,
  input  logic signed [bsr_pkg::CoordBits-1:0] x_coord_i,
  input  logic signed [bsr_pkg::CoordBits-1:0] y_coord_i,
  input  logic [bsr_pkg::WordBits-1:0]         write_value_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [bsr_pkg::WordBits-1:0]         read_value_o,
  output logic                                 range_error_o,
  // config port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [bsr_pkg::PaddrBits-1:0]        paddr,
  input  logic [bsr_pkg::PdataBits-1:0]        pwdata,
  output logic [bsr_pkg::PdataBits-1:0]        prdata,
  output logic                                 pready
);
  import bsr_pkg::*;

  // configuration
  logic [SizeBits-1:0] width_q, height_q;
  border_mode_e        mode_q;
  logic                cfg_wr;
  reg_idx_e            cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[PaddrBits-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
      mode_q   <= BmReplicate;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegWidth:  width_q  <= pwdata[SizeBits-1:0];
        RegHeight: height_q <= pwdata[SizeBits-1:0];
        RegMode:   mode_q   <= border_mode_e'(pwdata[1:0]);
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegWidth:  prdata = PdataBits'(width_q);
      RegHeight: prdata = PdataBits'(height_q);
      RegMode:   prdata = PdataBits'(mode_q);
      default:   prdata = '0;
    endcase
  end

  // held item
  state_e                state_q, state_d;
  action_e               act_q;
  logic signed [CoordBits-1:0] x_q, y_q;
  logic [WordBits-1:0]   wval_q;
  logic                  in_acc;

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q  <= action_e'(action_i);
      x_q    <= x_coord_i;
      y_q    <= y_coord_i;
      wval_q <= write_value_i;
    end
  end

  // coordinate classification
  logic [SizeBits-1:0] w_eff, h_eff;
  logic                in_x, in_y, in_mat, need_mod;

  assign w_eff  = eff_size(width_q, SizeBits'(MaxWidth));
  assign h_eff  = eff_size(height_q, SizeBits'(MaxHeight));
  assign in_x   = coord_inside(x_q, w_eff);
  assign in_y   = coord_inside(y_q, h_eff);
  assign in_mat = in_x && in_y;
  assign need_mod = (act_q == ActRead) && !in_mat
                    && (mode_q == BmReflect || mode_q == BmWrap);

  // remainder units, one per axis
  logic                 mod_start, busy_x, busy_y;
  logic [IdxBits-1:0]   rem_x, rem_y;

  bsr_mod_unit u_mod_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (fold_dividend(x_q, w_eff, mode_q)),
    .divisor_i  (w_eff),
    .busy_o     (busy_x),
    .rem_o      (rem_x)
  );

  bsr_mod_unit u_mod_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (fold_dividend(y_q, h_eff, mode_q)),
    .divisor_i  (h_eff),
    .busy_o     (busy_y),
    .rem_o      (rem_y)
  );

  // address of the folded coordinate
  logic [IdxBits-1:0]  map_x, map_y;
  logic [ProdBits-1:0] addr_full;
  logic                zero_out;

  assign map_x     = fold_coord(x_q, w_eff, mode_q, rem_x, in_x || act_q == ActWrite);
  assign map_y     = fold_coord(y_q, h_eff, mode_q, rem_y, in_y || act_q == ActWrite);
  assign addr_full = ProdBits'(map_y) * ProdBits'(w_eff) + ProdBits'(map_x);
  assign zero_out  = (mode_q == BmZero) && !in_mat;

  mem_req_t            mem_req;
  logic [WordBits-1:0] mem_rdata;

  bsr_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // output register
  logic                out_valid_q;
  logic [WordBits-1:0] read_value_q;
  logic                range_error_q;
  logic                out_load, out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_acc) state_d = StCheck;
      StCheck: state_d = need_mod ? StMod : StAddr;
      StMod:   if (!busy_x && !busy_y) state_d = StAddr;
      StAddr:  state_d = StMem;
      StMem:   if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // state outputs
  always_comb begin
    mod_start     = 1'b0;
    out_load      = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.re    = 1'b0;
    mem_req.addr  = AddrBits'(addr_full);
    mem_req.wdata = wval_q;
    unique case (state_q)
      StCheck: mod_start = need_mod;
      StAddr: begin
        mem_req.we = (act_q == ActWrite) && in_mat;
        mem_req.re = (act_q == ActRead) && !zero_out;
      end
      StMem:   out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      read_value_q  <= (act_q == ActRead && !zero_out) ? mem_rdata : '0;
      range_error_q <= (act_q == ActWrite) && !in_mat;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_value_o  = read_value_q;
  assign range_error_o = range_error_q;

  // checks
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && range_error_o |-> read_value_o == '0)
    else $error("range error beat carries read data");

  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == StCheck)
    else $error("accepted beat did not start the sequence");

  a_mod_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StIdle |-> !busy_x && !busy_y)
    else $error("remainder unit busy while idle");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StAddr && need_mod |->
      SizeBits'(rem_x) < w_eff && SizeBits'(rem_y) < h_eff)
    else $error("remainder not below divisor");

endmodule

### sv/bsr_mod_unit.sv
`timescale 1ns / 1ps
// bit-serial remainder of an unsigned coordinate by the configured matrix size
// depends on bsr_pkg

module bsr_mod_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [bsr_pkg::CoordBits-1:0]   dividend_i,
  input  logic [bsr_pkg::SizeBits-1:0]    divisor_i,
  output logic                            busy_o,
  output logic [bsr_pkg::IdxBits-1:0]     rem_o
);
  import bsr_pkg::*;

  logic                 busy_q, busy_d;
  logic [StepBits-1:0]  cnt_q, cnt_d;
  logic [IdxBits-1:0]   rem_q, rem_d;
  logic [CoordBits-1:0] dv_q, dv_d;
  logic [IdxBits:0]     trial;

  // restoring step: bring in the next dividend bit, subtract if it fits
  assign trial = {rem_q, dv_q[CoordBits-1]};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dv_d   = dv_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = StepBits'(CoordBits);
      rem_d  = '0;
      dv_d   = dividend_i;
    end else if (busy_q) begin
      dv_d  = {dv_q[CoordBits-2:0], 1'b0};
      cnt_d = cnt_q - StepBits'(1);
      if (trial >= divisor_i) begin
        rem_d = IdxBits'(trial - divisor_i);
      end else begin
        rem_d = IdxBits'(trial);
      end
      if (cnt_q == StepBits'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dv_q  <= dv_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

### sv/bsr_store.sv
`timescale 1ns / 1ps
// element store: one write and one read per cycle at one shared address, registered read data
// depends on bsr_pkg for the request struct and sizes

module bsr_store (
  input  logic                           clk_i,
  input  bsr_pkg::mem_req_t              req_i,
  output logic [bsr_pkg::WordBits-1:0]   rdata_o
);
  import bsr_pkg::*;

  logic [WordBits-1:0] mem [StoreDepth];
  logic [WordBits-1:0] rdata_q;

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
